// File: rtl/ard_pkg.sv
// Shared constants and control structures for the anti-repeat random draw core.
// Used by ard_ctrl, ard_dpath and anti_repeat_random_draw_core; depends on nothing.
package ard_pkg;

    localparam int HIST_DEPTH = 32;
    localparam int MAX_DRAWS  = 32;
    localparam int WIN_CAP    = 10;
    localparam int WARM_BASE  = 32;

    localparam int WIN_MAX = (WIN_CAP < HIST_DEPTH) ? WIN_CAP : HIST_DEPTH;
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int CHK_W   = $clog2(HIST_DEPTH + 2);
    localparam int WIN_W   = $clog2(WIN_MAX + 1);
    localparam int DRW_W   = $clog2(MAX_DRAWS + 1);
    localparam int WARM_W  = 6;

    localparam logic [31:0] SEED_C0 = 32'h0DD2_F1AA;
    localparam logic [31:0] SEED_C1 = 32'h69FB_E76D;
    localparam logic [31:0] SEED_C2 = 32'h3DF3_B646;
    localparam logic [31:0] SEED_C3 = 32'h40DD_E76D;
    localparam logic [31:0] SEED_C4 = 32'h68CD_851F;
    localparam logic [31:0] SEED_C5 = 32'h2E56_0419;

    localparam logic FUNC_INIT = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    typedef struct packed {
        logic       load;
        logic       seed_en;
        logic       add_en;
        logic       inc_en;
        logic       mul_en;
        logic       scan_init;
        logic       scan_step;
        logic       decide;
        logic       append;
        logic       out_load;
        logic       out_zero;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic              use_hist;
        logic [WARM_W-1:0] warm;
        logic              scan_done;
        logic              scan_hit;
    } t_stat;

endpackage

// File: rtl/ard_dpath.sv
// Datapath: generator words, multiplier, history store and its backward scan.
// Depends on ard_pkg; driven by ard_ctrl through t_cmd and reports through t_stat.
module ard_dpath
    import ard_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [31:0] i_seed,
    input  logic [15:0] i_limit,
    input  logic        i_use_history,
    input  logic [15:0] i_tag,
    output logic [15:0] o_value
);

    logic [31:0]        r_w [6];
    logic [31:0]        r_hist [HIST_DEPTH];
    logic [HIST_AW-1:0] r_wptr;

    logic [31:0]        r_s;
    logic [15:0]        r_limit;
    logic [15:0]        r_tag;
    logic               r_use_hist;
    logic [WIN_W-1:0]   r_window;
    logic [31:0]        r_ax;
    logic               r_c;
    logic [31:0]        r_gen;
    logic [15:0]        r_draw;
    logic [15:0]        r_best;
    logic [WIN_W-1:0]   r_oldest;
    logic               r_oldest_vld;
    logic [HIST_AW-1:0] r_idx;
    logic [CHK_W-1:0]   r_checks;
    logic [WIN_W-1:0]   r_tests;
    logic [15:0]        r_out;

    logic [31:0]        n_s;
    logic [14:0]        half;
    logic [WIN_W-1:0]   n_window;
    logic [2:0]         wi;
    logic [31:0]        add_a;
    logic [31:0]        add_b;
    logic [31:0]        n_ax;
    logic               n_c;
    logic [5:0]         inc;
    logic [31:0]        n_seed;
    logic [31:0]        seed_base;
    logic [31:0]        prod;
    logic [31:0]        entry;
    logic               tag_hit;
    logic               val_hit;
    logic               stop_miss;
    logic               hit;
    logic [HIST_AW-1:0] n_wptr;
    logic [WARM_W-1:0]  warm;

    assign n_s  = i_seed + {i_seed[15:0], 16'h0000};
    assign half = i_limit[15:1];
    assign n_window = (half > 15'(WIN_MAX)) ? WIN_W'(WIN_MAX) : WIN_W'(half);

    always_comb begin
        wi    = 3'd4 - i_cmd.idx;
        add_a = (i_cmd.idx == 3'd0) ? r_w[5] : r_ax;
        add_b = r_w[wi];
        n_ax  = add_a + add_b + ((i_cmd.idx == 3'd0) ? 32'd0 : {31'd0, r_c});
        if (i_cmd.idx == 3'd0) begin
            n_c = (n_ax < add_a) || (n_ax < add_b);
        end else begin
            n_c = n_ax < add_b;
        end
    end

    always_comb begin
        inc[5] = 1'b1;
        for (int i = 4; i >= 0; i--) begin
            inc[i] = inc[i+1] && (r_w[i+1] == 32'hFFFF_FFFF);
        end
    end

    always_comb begin
        seed_base = (i_cmd.idx == 3'd0) ? r_s : r_w[i_cmd.idx - 3'd1];
        case (i_cmd.idx)
            3'd0:    n_seed = seed_base - SEED_C0;
            3'd1:    n_seed = seed_base - SEED_C1;
            3'd2:    n_seed = seed_base + SEED_C2;
            3'd3:    n_seed = seed_base + SEED_C3;
            3'd4:    n_seed = seed_base - SEED_C4;
            default: n_seed = seed_base - SEED_C5;
        endcase
    end

    assign prod = r_gen[31:16] * r_limit;

    assign entry     = r_hist[r_idx];
    assign tag_hit   = entry[31:16] == r_tag;
    assign val_hit   = entry[15:0] == r_draw;
    assign stop_miss = (r_tests >= r_window) || (r_checks == CHK_W'(HIST_DEPTH + 1));
    assign hit       = !stop_miss && tag_hit && val_hit;

    assign n_wptr = (r_wptr == HIST_AW'(HIST_DEPTH - 1)) ? '0 : r_wptr + 1'b1;

    assign warm = r_s[31] ? (WARM_W'(WARM_BASE) + {1'b0, 5'(32'd0 - r_s)})
                          : (WARM_W'(WARM_BASE) - {1'b0, r_s[4:0]});

    assign o_stat.use_hist  = r_use_hist;
    assign o_stat.warm      = warm;
    assign o_stat.scan_done = stop_miss || hit;
    assign o_stat.scan_hit  = hit;
    assign o_value          = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_w[i] <= '0;
            end
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '1;
            end
            r_wptr <= '0;
        end else begin
            if (i_cmd.seed_en) begin
                r_w[i_cmd.idx] <= n_seed;
                if (i_cmd.idx == 3'd0) begin
                    for (int i = 0; i < HIST_DEPTH; i++) begin
                        r_hist[i] <= '1;
                    end
                    r_wptr <= '0;
                end
            end
            if (i_cmd.add_en) begin
                r_w[wi] <= n_ax;
            end
            if (i_cmd.inc_en) begin
                for (int i = 0; i < 6; i++) begin
                    if (inc[i]) begin
                        r_w[i] <= r_w[i] + 32'd1;
                    end
                end
            end
            if (i_cmd.append) begin
                r_hist[n_wptr] <= {r_tag, r_best};
                r_wptr         <= n_wptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s          <= n_s;
            r_limit      <= i_limit;
            r_tag        <= i_tag;
            r_use_hist   <= i_use_history;
            r_window     <= n_window;
            r_oldest_vld <= 1'b0;
        end
        if (i_cmd.add_en) begin
            r_ax <= n_ax;
            r_c  <= n_c;
        end
        if (i_cmd.inc_en) begin
            r_gen <= inc[0] ? (r_w[0] + 32'd1) : r_ax;
        end
        if (i_cmd.mul_en) begin
            r_draw <= prod[31:16];
        end
        if (i_cmd.scan_init) begin
            r_idx    <= r_wptr;
            r_checks <= '0;
            r_tests  <= '0;
        end else if (i_cmd.scan_step && !(stop_miss || hit)) begin
            if (tag_hit) begin
                r_tests <= r_tests + 1'b1;
            end
            r_idx    <= (r_idx == '0) ? HIST_AW'(HIST_DEPTH - 1) : r_idx - 1'b1;
            r_checks <= r_checks + 1'b1;
        end
        if (i_cmd.decide) begin
            if (!hit) begin
                r_best <= r_draw;
            end else if (!r_oldest_vld || (r_tests > r_oldest)) begin
                r_oldest     <= r_tests;
                r_oldest_vld <= 1'b1;
                r_best       <= r_draw;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= i_cmd.out_zero ? 16'h0000 : r_draw;
        end
    end

endmodule

// File: rtl/ard_ctrl.sv
// Sequencer for seeding, warm-up, generator steps, history scans and result hand-off.
// Depends on ard_pkg; commands ard_dpath through t_cmd and reads its t_stat.
module ard_ctrl
    import ard_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_func,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_ADD,
        S_INC,
        S_MUL,
        S_SCAN,
        S_APPEND,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [2:0]         r_k;
    logic [WARM_W-1:0]  r_cnt;
    logic [DRW_W-1:0]   r_draw_cnt;
    logic               r_init;
    logic               r_out_valid;

    logic               accept;
    logic               last_draw;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign last_draw   = (r_draw_cnt == DRW_W'(MAX_DRAWS - 1));

    always_comb begin
        o_cmd           = '0;
        o_cmd.idx       = r_k;
        o_cmd.out_zero  = r_init;
        o_cmd.load      = accept;
        o_cmd.seed_en   = (r_state == S_SEED);
        o_cmd.add_en    = (r_state == S_ADD);
        o_cmd.inc_en    = (r_state == S_INC);
        o_cmd.mul_en    = (r_state == S_MUL);
        o_cmd.scan_init = (r_state == S_MUL);
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.decide    = (r_state == S_SCAN) && i_stat.scan_done;
        o_cmd.append    = (r_state == S_APPEND);
        o_cmd.out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_cnt       <= '0;
            r_draw_cnt  <= '0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_k        <= '0;
                        r_draw_cnt <= '0;
                        r_init     <= (i_func == FUNC_INIT);
                        r_state    <= (i_func == FUNC_INIT) ? S_SEED : S_ADD;
                    end
                end
                S_SEED: begin
                    if (r_k == 3'd5) begin
                        r_k     <= '0;
                        r_cnt   <= i_stat.warm;
                        r_state <= S_ADD;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_ADD: begin
                    if (r_k == 3'd4) begin
                        r_k     <= '0;
                        r_state <= S_INC;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_INC: begin
                    if (r_init) begin
                        if (r_cnt == WARM_W'(1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cnt   <= r_cnt - 1'b1;
                            r_state <= S_ADD;
                        end
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= i_stat.use_hist ? S_SCAN : S_DONE;
                end
                S_SCAN: begin
                    if (i_stat.scan_done) begin
                        if (!i_stat.scan_hit || last_draw) begin
                            r_state <= S_APPEND;
                        end else begin
                            r_draw_cnt <= r_draw_cnt + 1'b1;
                            r_state    <= S_ADD;
                        end
                    end
                end
                S_APPEND: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/anti_repeat_random_draw_core.sv
// Top level of the anti-repeat random draw core: joins ard_ctrl and ard_dpath.
// Depends on ard_pkg, ard_ctrl and ard_dpath.
//
// One beat in gives one beat out, and the core works on one request at a time. A generator
// step runs its five chained word additions through one shared 32-bit adder and then
// increments. A plain draw is one generator step and a multiply. Each pass of a tagged
// draw takes one step, a multiply and a history scan of one entry a cycle. There are
// at most 32 passes, and an append step then stores the kept draw. Initialise writes
// the six seed words in turn and then runs 1 to 63 warm-up generator steps. A finished
// result waits in the output register, and the next request beat may be taken while it
// does.
module anti_repeat_random_draw_core
    import ard_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [31:0] i_seed,
    input  logic [15:0] i_limit,
    input  logic        i_use_history,
    input  logic [15:0] i_tag,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_value
);

    t_cmd  cmd;
    t_stat stat;

    ard_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ard_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_seed        (i_seed),
        .i_limit       (i_limit),
        .i_use_history (i_use_history),
        .i_tag         (i_tag),
        .o_value       (o_value)
    );

endmodule

// File: verif/tb_anti_repeat_random_draw_core.sv
// Self-checking testbench for anti_repeat_random_draw_core: a directed table, then random beats
// under four idling phases, every result checked against an in-bench model of the generator
// or, for checked table rows, the table's own value. Depends on ard_pkg and the anti_repeat_random_draw_core RTL.
module tb_anti_repeat_random_draw_core
    import ard_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WARMUP_LIMIT   = 10;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 400;
    localparam int DIR_N          = 22;

    typedef struct packed {
        logic        func;
        logic [31:0] seed;
        logic [15:0] limit;
        logic        use_hist;
        logic [15:0] tag;
        logic        chk;
        logic [15:0] value;
    } t_item;

    localparam t_item DIR_TAB [DIR_N] = '{
        '{FUNC_DRAW, 32'h0000_0000, 16'hFFFF, 1'b0, 16'h0000, 1'b1, 16'h0000},
        '{FUNC_DRAW, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 16'h0000},
        '{FUNC_INIT, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0000, 1'b1, 16'h0005, 1'b1, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0001, 1'b1, 16'h0005, 1'b1, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0002, 1'b1, 16'h0005, 1'b0, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0002, 1'b1, 16'h0005, 1'b0, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0002, 1'b1, 16'h0005, 1'b0, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0014, 1'b1, 16'h0005, 1'b0, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0014, 1'b1, 16'h0005, 1'b0, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 16'h0000},
        '{FUNC_DRAW, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
        '{FUNC_INIT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'h0000},
        '{FUNC_INIT, 32'h0000_001F, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0000},
        '{FUNC_INIT, 32'h8000_0000, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0003, 1'b1, 16'h0000, 1'b0, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0015, 1'b1, 16'h0000, 1'b0, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h1F40, 1'b0, 16'h0000, 1'b0, 16'h0000},
        '{FUNC_INIT, 32'h1234_5678, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0002, 1'b1, 16'h0000, 1'b0, 16'h0000},
        '{FUNC_DRAW, 32'h0000_0000, 16'h0002, 1'b1, 16'h0000, 1'b0, 16'h0000}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic        i_func        = FUNC_INIT;
    logic [31:0] i_seed        = '0;
    logic [15:0] i_limit       = '0;
    logic        i_use_history = 1'b0;
    logic [15:0] i_tag         = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [15:0] o_value;

    logic [31:0] gen_w [6];
    logic [31:0] hist_mem [HIST_DEPTH];
    int unsigned hist_wp;

    logic [15:0] value_q [$];
    logic [15:0] want_value;
    int          mismatch_cnt = 0;
    int          stall_cycles = 0;
    int          in_idle_pct  = 0;
    int          out_stall_pct = 0;
    bit          hold_req     = 1'b0;

    anti_repeat_random_draw_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_seed        (i_seed),
        .i_limit       (i_limit),
        .i_use_history (i_use_history),
        .i_tag         (i_tag),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] next_gen_word();
        logic [31:0] ax;
        logic        c;
        ax = gen_w[5] + gen_w[4];
        c = (ax < gen_w[5]) || (ax < gen_w[4]);
        gen_w[4] = ax;
        for (int i = 3; i >= 0; i--) begin
            ax = ax + gen_w[i] + {31'd0, c};
            c = (ax < gen_w[i]);
            gen_w[i] = ax;
        end
        for (int i = 5; i >= 1; i--) begin
            gen_w[i] = gen_w[i] + 32'd1;
            if (gen_w[i] != 32'd0)
                return ax;
        end
        gen_w[0] = gen_w[0] + 32'd1;
        return gen_w[0];
    endfunction

    function automatic logic [15:0] scaled_draw(input logic [15:0] lim);
        logic [31:0] w;
        logic [31:0] prod;
        w = next_gen_word();
        prod = {16'd0, w[31:16]} * {16'd0, lim};
        return prod[31:16];
    endfunction

    function automatic int recent_match_pos(input logic [15:0] val, input int unsigned win,
                                            input logic [15:0] tg);
        int unsigned idx;
        int unsigned hits;
        idx = hist_wp;
        hits = 0;
        if (win > HIST_DEPTH)
            win = HIST_DEPTH;
        for (int k = 0; k <= HIST_DEPTH; k++) begin
            if (hits >= win)
                return -1;
            if (hist_mem[idx][31:16] == tg) begin
                hits++;
                if (hist_mem[idx][15:0] == val)
                    return int'(hits) - 1;
            end
            idx = (idx == 0) ? HIST_DEPTH - 1 : idx - 1;
        end
        return -1;
    endfunction

    function automatic logic [15:0] predict_value(input t_item it);
        logic [31:0] s;
        int unsigned warm;
        int unsigned win;
        int unsigned tries;
        logic [15:0] last;
        logic [15:0] kept;
        int          oldest;
        int          pos;
        logic        stop;
        if (hist_wp >= HIST_DEPTH)
            hist_wp = 0;
        if (it.func == FUNC_INIT) begin
            s = it.seed + (it.seed << 16);
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_mem[i] = '1;
            hist_wp = 0;
            gen_w[0] = s - SEED_C0;
            gen_w[1] = gen_w[0] - SEED_C1;
            gen_w[2] = gen_w[1] + SEED_C2;
            gen_w[3] = gen_w[2] + SEED_C3;
            gen_w[4] = gen_w[3] - SEED_C4;
            gen_w[5] = gen_w[4] - SEED_C5;
            if (!s[31])
                warm = WARM_BASE - s[4:0];
            else
                warm = WARM_BASE + ((32'd0 - s) & 32'd31);
            repeat (warm) void'(scaled_draw(16'(WARMUP_LIMIT)));
            return 16'd0;
        end
        win = it.limit / 2;
        if (win > WIN_CAP)
            win = WIN_CAP;
        last = scaled_draw(it.limit);
        kept = last;
        if (it.use_hist) begin
            oldest = -1;
            tries = 0;
            stop = 1'b0;
            while (!stop) begin
                pos = recent_match_pos(last, win, it.tag);
                if (pos < 0) begin
                    kept = last;
                    stop = 1'b1;
                end else if (pos > oldest) begin
                    oldest = pos;
                    kept = last;
                end
                tries++;
                if (tries > MAX_DRAWS - 1)
                    stop = 1'b1;
                if (!stop)
                    last = scaled_draw(it.limit);
            end
            hist_wp = (hist_wp >= HIST_DEPTH - 1) ? 0 : hist_wp + 1;
            hist_mem[hist_wp] = {it.tag, kept};
        end
        return last;
    endfunction

    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        it.func = ($urandom_range(0, 99) < 3) ? FUNC_INIT : FUNC_DRAW;
        pick = $urandom_range(0, 9);
        it.seed = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            it.limit = 16'($urandom_range(0, 24));
        else if (pick < 80)
            it.limit = 16'($urandom_range(25, 400));
        else if (pick < 95)
            it.limit = 16'($urandom);
        else
            it.limit = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        it.use_hist = ($urandom_range(0, 99) < 75);
        it.tag = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        it.chk = 1'b0;
        it.value = '0;
        return it;
    endfunction

    // Offers one beat and returns at the edge that accepts it, with valid still high.
    task automatic offer(input t_item it);
        logic [15:0] pred;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= it.func;
        i_seed        <= it.seed;
        i_limit       <= it.limit;
        i_use_history <= it.use_hist;
        i_tag         <= it.tag;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pred = predict_value(it);
        value_q.push_back(it.chk ? it.value : pred);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (value_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual value %h",
                         $time, o_value);
                mismatch_cnt++;
            end else begin
                want_value = value_q.pop_front();
                if (o_value !== want_value) begin
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, want_value, o_value);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired at %0t", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 6; i++)
            gen_w[i] = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
            hist_mem[i] = '1;
        hist_wp = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TAB[i])
            offer(DIR_TAB[i]);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_idle_pct = 50;
                    out_stall_pct = 0;
                end
                2: begin
                    in_idle_pct = 0;
                    out_stall_pct = 50;
                end
                default: begin
                    in_idle_pct = 38;
                    out_stall_pct = 38;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 100)
                    hold_req = 1'b1;
                if (ph == 2 && n == 200) begin
                    i_in_valid <= 1'b0;
                    while (value_q.size() != 0)
                        @(posedge i_clk);
                end
                offer(random_item());
            end
        end
        i_in_valid <= 1'b0;

        while (value_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
